// ===== hw/rtl/dpec_pkg.sv =====
// shared widths, payload type and saturation helper for the disc pair collision block
package dpec_pkg;

  localparam int POS_W              = 16;
  localparam int VEL_W              = 16;
  localparam int RAD_W              = 10;
  localparam int D_W                = POS_W + 1;
  localparam int DD_W               = 2 * D_W + 1;
  localparam int DOT_W              = 2 * D_W + 1;
  localparam int PROD_W             = DOT_W + D_W;
  localparam int NUM_W              = PROD_W;
  localparam int DEN_W              = DD_W + 1;
  localparam int Q_W                = VEL_W + 1;
  localparam int QS_W               = Q_W + 1;
  localparam int NV_W               = QS_W + 1;
  localparam int FIFO_DEPTH         = 4;
  localparam int POS_FRAC_BITS_DEF  = 4;

  // classified pair handed from front to back
  typedef struct packed {
    logic signed [VEL_W-1:0] avx;
    logic signed [VEL_W-1:0] avy;
    logic signed [VEL_W-1:0] bvx;
    logic signed [VEL_W-1:0] bvy;
    logic signed [D_W-1:0]   dx;
    logic signed [D_W-1:0]   dy;
    logic [DD_W-1:0]         dd;
    logic signed [DOT_W-1:0] dot;
    logic                    ovl;
    logic                    exch;
  } cls_t;

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [NV_W-1:0] v);
    logic signed [NV_W-1:0] hi;
    logic signed [NV_W-1:0] lo;
    hi = NV_W'(signed'({1'b0, {(VEL_W-1){1'b1}}}));
    lo = NV_W'(signed'({1'b1, {(VEL_W-1){1'b0}}}));
    if (v > hi) begin
      sat_vel = hi[VEL_W-1:0];
    end else if (v < lo) begin
      sat_vel = lo[VEL_W-1:0];
    end else begin
      sat_vel = v[VEL_W-1:0];
    end
  endfunction

endpackage

// ===== hw/rtl/dpec_front.sv =====
// front pipeline: differences, products, overlap and approach test
module dpec_front #(
  parameter int POS_FRAC_BITS = dpec_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dpec_pkg::POS_W-1:0]    a_pos_x,
  input  logic [dpec_pkg::POS_W-1:0]    a_pos_y,
  input  logic signed [dpec_pkg::VEL_W-1:0] a_vel_x,
  input  logic signed [dpec_pkg::VEL_W-1:0] a_vel_y,
  input  logic [dpec_pkg::RAD_W-1:0]    a_radius,
  input  logic [dpec_pkg::POS_W-1:0]    b_pos_x,
  input  logic [dpec_pkg::POS_W-1:0]    b_pos_y,
  input  logic signed [dpec_pkg::VEL_W-1:0] b_vel_x,
  input  logic signed [dpec_pkg::VEL_W-1:0] b_vel_y,
  input  logic [dpec_pkg::RAD_W-1:0]    b_radius,
  input  logic                          q_full,
  output logic                          push,
  output dpec_pkg::cls_t                item
);
  import dpec_pkg::*;

  localparam int RS_W  = RAD_W + 1 + POS_FRAC_BITS;
  localparam int RS2_W = 2 * RS_W;
  localparam int CMP_W = (RS2_W > DD_W) ? RS2_W : DD_W;

  logic v1, v2, v3;
  logic en;

  logic signed [D_W-1:0]   dx1, dy1, dvx1, dvy1;
  logic [RS_W-1:0]         rs1;
  logic signed [D_W-1:0]   dx2, dy2, dx3, dy3;
  logic signed [2*D_W-1:0] sqx2, sqy2, pdx2, pdy2;
  logic [RS2_W-1:0]        rs2_2, rs2_3;
  logic [DD_W-1:0]         dd3;
  logic signed [DOT_W-1:0] dot3;
  logic signed [VEL_W-1:0] avx1, avy1, bvx1, bvy1;
  logic signed [VEL_W-1:0] avx2, avy2, bvx2, bvy2;
  logic signed [VEL_W-1:0] avx3, avy3, bvx3, bvy3;
  logic [RAD_W:0]          rsum;
  logic                    ovl;

  assign en       = !v3 || !q_full;
  assign in_ready = en;
  assign push     = v3 && !q_full;
  assign rsum     = {1'b0, a_radius} + {1'b0, b_radius};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1   <= $signed({1'b0, a_pos_x}) - $signed({1'b0, b_pos_x});
      dy1   <= $signed({1'b0, a_pos_y}) - $signed({1'b0, b_pos_y});
      dvx1  <= $signed({a_vel_x[VEL_W-1], a_vel_x}) - $signed({b_vel_x[VEL_W-1], b_vel_x});
      dvy1  <= $signed({a_vel_y[VEL_W-1], a_vel_y}) - $signed({b_vel_y[VEL_W-1], b_vel_y});
      rs1   <= RS_W'(rsum) << POS_FRAC_BITS;
      avx1  <= a_vel_x;
      avy1  <= a_vel_y;
      bvx1  <= b_vel_x;
      bvy1  <= b_vel_y;

      sqx2  <= dx1 * dx1;
      sqy2  <= dy1 * dy1;
      pdx2  <= dvx1 * dx1;
      pdy2  <= dvy1 * dy1;
      rs2_2 <= rs1 * rs1;
      dx2   <= dx1;
      dy2   <= dy1;
      avx2  <= avx1;
      avy2  <= avy1;
      bvx2  <= bvx1;
      bvy2  <= bvy1;

      dd3   <= {1'b0, sqx2} + {1'b0, sqy2};
      dot3  <= DOT_W'(pdx2) + DOT_W'(pdy2);
      rs2_3 <= rs2_2;
      dx3   <= dx2;
      dy3   <= dy2;
      avx3  <= avx2;
      avy3  <= avy2;
      bvx3  <= bvx2;
      bvy3  <= bvy2;
    end
  end

  assign ovl = CMP_W'(rs2_3) > CMP_W'(dd3);

  always_comb begin
    item.avx  = avx3;
    item.avy  = avy3;
    item.bvx  = bvx3;
    item.bvy  = bvy3;
    item.dx   = dx3;
    item.dy   = dy3;
    item.dd   = dd3;
    item.dot  = dot3;
    item.ovl  = ovl;
    // overlapping, approaching and not coincident
    item.exch = ovl && dot3[DOT_W-1] && (dd3 != '0);
  end

endmodule

// ===== hw/rtl/dpec_fifo.sv =====
// short queue of classified pairs between front and back
module dpec_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  dpec_pkg::cls_t wdata,
  input  logic           pop,
  output dpec_pkg::cls_t rdata,
  output logic           full,
  output logic           empty
);
  import dpec_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);

  cls_t          mem [FIFO_DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;

  assign full  = count == (AW+1)'(FIFO_DEPTH);
  assign empty = count == '0;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(FIFO_DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(FIFO_DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/dpec_div.sv =====
// pipelined rounding divider, one quotient bit per stage
module dpec_div (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [dpec_pkg::PROD_W-1:0] prod,
  input  logic [dpec_pkg::DD_W-1:0]          dd,
  output logic signed [dpec_pkg::QS_W-1:0]   q
);
  import dpec_pkg::*;

  logic [NUM_W-1:0]  rem  [Q_W+1];
  logic [Q_W-1:0]    qt   [Q_W+1];
  logic [DEN_W-1:0]  den  [Q_W+1];
  logic              neg  [Q_W+1];
  logic [PROD_W-1:0] mag;

  assign mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);

  // round half away from zero: (2|n| + d) / (2d)
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= NUM_W'(mag << 1) + NUM_W'(dd);
      den[0] <= {dd, 1'b0};
      qt[0]  <= '0;
      neg[0] <= prod[PROD_W-1];
    end
  end

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    localparam int K = Q_W - 1 - i;
    logic take;
    assign take = (rem[i] >> K) >= NUM_W'(den[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= take ? rem[i] - (NUM_W'(den[i]) << K) : rem[i];
        qt[i+1]  <= {qt[i][Q_W-2:0], take};
        den[i+1] <= den[i];
        neg[i+1] <= neg[i];
      end
    end
  end

  assign q = neg[Q_W] ? -$signed({1'b0, qt[Q_W]}) : $signed({1'b0, qt[Q_W]});

endmodule

// ===== hw/rtl/dpec_back.sv =====
// back pipeline: normal impulse, division, velocity update and output register
module dpec_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  input  dpec_pkg::cls_t                    item,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dpec_pkg::VEL_W-1:0] a_new_vel_x,
  output logic signed [dpec_pkg::VEL_W-1:0] a_new_vel_y,
  output logic signed [dpec_pkg::VEL_W-1:0] b_new_vel_x,
  output logic signed [dpec_pkg::VEL_W-1:0] b_new_vel_y,
  output logic                              overlap,
  output logic                              exchanged
);
  import dpec_pkg::*;

  localparam int LAT = Q_W + 2;

  logic                     en;
  logic                     vb   [LAT];
  cls_t                     side [LAT];
  logic signed [PROD_W-1:0] prodx, prody;
  logic signed [QS_W-1:0]   qx, qy;
  cls_t                     t;

  assign en  = !out_valid || out_ready;
  assign pop = en && !q_empty;
  assign t   = side[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < LAT; j++) begin
        vb[j] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (en) begin
      vb[0] <= !q_empty;
      for (int j = 1; j < LAT; j++) begin
        vb[j] <= vb[j-1];
      end
      out_valid <= vb[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prodx   <= item.dot * item.dx;
      prody   <= item.dot * item.dy;
      side[0] <= item;
      for (int j = 1; j < LAT; j++) begin
        side[j] <= side[j-1];
      end
    end
  end

  dpec_div u_div_x (
    .clk  (clk),
    .en   (en),
    .prod (prodx),
    .dd   (side[0].dd),
    .q    (qx)
  );

  dpec_div u_div_y (
    .clk  (clk),
    .en   (en),
    .prod (prody),
    .dd   (side[0].dd),
    .q    (qy)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      overlap   <= t.ovl;
      exchanged <= t.exch;
      if (t.exch) begin
        a_new_vel_x <= sat_vel(NV_W'(t.avx) - NV_W'(qx));
        a_new_vel_y <= sat_vel(NV_W'(t.avy) - NV_W'(qy));
        b_new_vel_x <= sat_vel(NV_W'(t.bvx) + NV_W'(qx));
        b_new_vel_y <= sat_vel(NV_W'(t.bvy) + NV_W'(qy));
      end else begin
        a_new_vel_x <= t.avx;
        a_new_vel_y <= t.avy;
        b_new_vel_x <= t.bvx;
        b_new_vel_y <= t.bvy;
      end
    end
  end

endmodule

// ===== hw/rtl/disc_pair_elastic_collision.sv =====
// top level of the equal-mass disc pair elastic collision block
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  input    | in_valid / in_ready    | a_/b_ pos_x, pos_y, vel_x, vel_y, radius
//  output   | out_valid / out_ready  | a_/b_ new_vel_x, new_vel_y, overlap, exchanged
//
// one pair per cycle sustained unless the output stalls; pairs pass front,
// queue, then back (product, divider prep, 17 quotient-bit stages, output register)
// the 17-stage restoring divider pipeline sets the latency
// rst is synchronous; it empties the pipelines and the 4-entry queue
// an output stall freezes the back pipeline; the front keeps taking pairs
// until the queue is full
module disc_pair_elastic_collision #(
  parameter int POS_FRAC_BITS = dpec_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dpec_pkg::POS_W-1:0]        a_pos_x,
  input  logic [dpec_pkg::POS_W-1:0]        a_pos_y,
  input  logic signed [dpec_pkg::VEL_W-1:0] a_vel_x,
  input  logic signed [dpec_pkg::VEL_W-1:0] a_vel_y,
  input  logic [dpec_pkg::RAD_W-1:0]        a_radius,
  input  logic [dpec_pkg::POS_W-1:0]        b_pos_x,
  input  logic [dpec_pkg::POS_W-1:0]        b_pos_y,
  input  logic signed [dpec_pkg::VEL_W-1:0] b_vel_x,
  input  logic signed [dpec_pkg::VEL_W-1:0] b_vel_y,
  input  logic [dpec_pkg::RAD_W-1:0]        b_radius,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dpec_pkg::VEL_W-1:0] a_new_vel_x,
  output logic signed [dpec_pkg::VEL_W-1:0] a_new_vel_y,
  output logic signed [dpec_pkg::VEL_W-1:0] b_new_vel_x,
  output logic signed [dpec_pkg::VEL_W-1:0] b_new_vel_y,
  output logic                              overlap,
  output logic                              exchanged
);
  import dpec_pkg::*;

  logic push, pop, q_full, q_empty;
  cls_t f_item, b_item;

  dpec_front #(
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .a_pos_x  (a_pos_x),
    .a_pos_y  (a_pos_y),
    .a_vel_x  (a_vel_x),
    .a_vel_y  (a_vel_y),
    .a_radius (a_radius),
    .b_pos_x  (b_pos_x),
    .b_pos_y  (b_pos_y),
    .b_vel_x  (b_vel_x),
    .b_vel_y  (b_vel_y),
    .b_radius (b_radius),
    .q_full   (q_full),
    .push     (push),
    .item     (f_item)
  );

  dpec_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (f_item),
    .pop   (pop),
    .rdata (b_item),
    .full  (q_full),
    .empty (q_empty)
  );

  dpec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .item        (b_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .a_new_vel_x (a_new_vel_x),
    .a_new_vel_y (a_new_vel_y),
    .b_new_vel_x (b_new_vel_x),
    .b_new_vel_y (b_new_vel_y),
    .overlap     (overlap),
    .exchanged   (exchanged)
  );

endmodule
